// ===== sv/dau_pkg.sv =====
// shared types and codes for the duration arithmetic unit
`default_nettype none
package dau_pkg;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_RAT = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DIV0 = 2'd1,
    ERR_OVF  = 2'd2
  } err_e;

  localparam int unsigned FuncBits = 3;
  localparam int unsigned ScalarBits = 32;
  localparam int unsigned ErrBits = 2;

endpackage
`default_nettype wire

// ===== sv/duration_arith_unit_core.sv =====
// top level of the duration arithmetic unit: sequencer around serial mul and div
//
// channel  | dir | fields
// s_axis   | in  | tdata: func, a_ticks, a_unit, b_ticks, b_unit, scalar
// m_axis   | out | tdata: res_ticks, res_unit, quotient, error
//
// one item at a time, W = max(TICK_BITS, UNIT_BITS, 32): the multiplier is W bits wide
// and the divider 2*W. add/sub run the euclid loop (one division per step,
// up to about 1.5*UNIT_BITS steps), then two scaling divisions and two multiplies.
// mul takes one multiply, div one division, ratio two multiplies and a division.
// reset idles the sequencer. a held result stalls new input until taken.
`default_nettype none
module duration_arith_unit_core
  import dau_pkg::*;
#(
  parameter int unsigned TICK_BITS = 48,
  parameter int unsigned UNIT_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // func, a_ticks, a_unit, b_ticks, b_unit, scalar (lowest first)
  input  wire logic [((FuncBits+2*TICK_BITS+2*UNIT_BITS+ScalarBits+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // res_ticks, res_unit, quotient, error (lowest first)
  output logic [((2*TICK_BITS+UNIT_BITS+ErrBits+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned T = TICK_BITS;
  localparam int unsigned U = UNIT_BITS;
  localparam int unsigned MW = (T > U) ? ((T > ScalarBits) ? T : ScalarBits)
                                       : ((U > ScalarBits) ? U : ScalarBits);
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned OW = ((2*T+U+ErrBits+7)/8)*8;
  localparam int unsigned OP = OW - (2*T+U+ErrBits);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_GCD   = 9'b000000010,
    ST_SCL   = 9'b000000100,
    ST_MULA  = 9'b000001000,
    ST_MULB  = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_QDIV  = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e state_q;

  logic [FuncBits-1:0] func_q;
  logic [T-1:0] am_q, bm_q;
  logic         an_q, bn_q;
  logic [U-1:0] au_q, bu_q, gx_q, gy_q;
  logic [ScalarBits-1:0] sc_q;
  logic [PW-1:0] pa_q, pb_q;
  logic [T-1:0]  rt_q, q_q;
  logic [U-1:0]  ru_q;
  logic [ErrBits-1:0] err_q;
  logic [1:0]    scl_q;

  // input unpack
  logic [FuncBits-1:0] in_func;
  logic [T-1:0] in_at, in_bt;
  logic [U-1:0] in_au, in_bu;
  logic [ScalarBits-1:0] in_sc;
  assign in_func = s_axis_tdata[FuncBits-1:0];
  assign in_at   = s_axis_tdata[FuncBits +: T];
  assign in_au   = s_axis_tdata[FuncBits+T +: U];
  assign in_bt   = s_axis_tdata[FuncBits+T+U +: T];
  assign in_bu   = s_axis_tdata[FuncBits+2*T+U +: U];
  assign in_sc   = s_axis_tdata[FuncBits+2*T+2*U +: ScalarBits];

  // serial multiplier
  logic          mul_start, mul_busy, mul_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  dau_sermul #(.W(MW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .done_o(mul_done), .prod_o(mul_p)
  );

  // serial divider, wide enough for the ratio
  logic          div_start, div_busy, div_done;
  logic [PW-1:0] div_n, div_d, div_quo, div_rem;
  dau_serdiv #(.W(PW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_n), .den_i(div_d),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // saturating pack of sign and magnitude
  function automatic logic [T:0] sat_pack(input logic neg, input logic [PW:0] m);
    logic [PW:0]  lim;
    logic [T-1:0] mag;
    logic         ovf;
    lim = neg ? (PW+1)'({1'b1, {(T-1){1'b0}}}) : (PW+1)'({(T-1){1'b1}});
    ovf = m > lim;
    mag = ovf ? lim[T-1:0] : m[T-1:0];
    sat_pack = {ovf, neg ? (T)'(~mag + 1'b1) : mag};
  endfunction

  logic [PW:0] sum;
  logic        sum_neg, sn_eff;
  logic [T:0]  pk_add, pk_mul, pk_div, pk_q;

  always_comb begin
    sn_eff = (func_q == FUNC_SUB) ? !bn_q : bn_q;
    if (pb_q == '0) sn_eff = an_q;
    if (an_q == sn_eff) begin
      sum = {1'b0, pa_q} + {1'b0, pb_q};
      sum_neg = an_q;
    end else if (pa_q >= pb_q) begin
      sum = {1'b0, pa_q - pb_q};
      sum_neg = an_q;
    end else begin
      sum = {1'b0, pb_q - pa_q};
      sum_neg = sn_eff;
    end
    if (sum == '0) sum_neg = 1'b0;
  end

  assign pk_add = sat_pack(sum_neg, sum);
  assign pk_mul = sat_pack(an_q && (pa_q != '0), {1'b0, pa_q});
  assign pk_div = sat_pack(an_q && (div_quo != '0), {1'b0, div_quo});
  assign pk_q   = sat_pack((an_q != bn_q) && (div_quo != '0), {1'b0, div_quo});

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {{OP{1'b0}}, err_q, q_q, ru_q, rt_q};

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_q)
      ST_GCD: begin
        div_start = !div_busy && !div_done && gy_q != '0;
        div_n = PW'(gx_q);
        div_d = PW'(gy_q);
      end
      ST_SCL: begin
        div_start = !div_busy && !div_done && scl_q != 2'd2;
        div_n = (scl_q == 2'd0) ? PW'(au_q) : PW'(bu_q);
        div_d = PW'(gx_q);
      end
      ST_MULA: begin
        mul_start = !mul_busy && !mul_done;
        mul_a = MW'(am_q);
        mul_b = (func_q == FUNC_MUL) ? MW'(sc_q) : MW'(au_q);
      end
      ST_MULB: begin
        mul_start = !mul_busy && !mul_done;
        mul_a = MW'(bm_q);
        mul_b = MW'(bu_q);
      end
      ST_DIV: begin
        div_start = !div_busy && !div_done;
        div_n = PW'(am_q);
        div_d = PW'(sc_q);
      end
      ST_QDIV: begin
        // a zero denominator leaves at once, with no division running behind
        div_start = !div_busy && !div_done && pb_q != '0;
        div_n = pa_q;
        div_d = pb_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scl_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          scl_q <= '0;
          unique case (in_func)
            FUNC_ADD, FUNC_SUB: state_q <= ST_GCD;
            FUNC_MUL, FUNC_RAT: state_q <= ST_MULA;
            FUNC_DIV: state_q <= (in_sc == '0) ? ST_OUT : ST_DIV;
            default: state_q <= ST_OUT;
          endcase
        end
        ST_GCD: begin
          if (gy_q == '0) begin
            state_q <= (gx_q == '0) ? ST_OUT : ST_SCL;
          end
        end
        ST_SCL: begin
          if (div_done) scl_q <= scl_q + 2'd1;
          if (scl_q == 2'd2) state_q <= ST_MULA;
        end
        ST_MULA: if (mul_done) begin
          state_q <= (func_q == FUNC_MUL) ? ST_FIN : ST_MULB;
        end
        ST_MULB: if (mul_done) begin
          state_q <= (func_q == FUNC_RAT) ? ST_QDIV : ST_FIN;
        end
        ST_QDIV: begin
          if (pb_q == '0) state_q <= ST_OUT;
          else if (div_done) state_q <= ST_FIN;
        end
        ST_DIV: if (div_done) state_q <= ST_FIN;
        ST_FIN: state_q <= ST_OUT;
        ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) begin
        func_q <= in_func;
        an_q   <= in_at[T-1];
        bn_q   <= in_bt[T-1];
        am_q   <= in_at[T-1] ? (T)'(~in_at + 1'b1) : in_at;
        bm_q   <= in_bt[T-1] ? (T)'(~in_bt + 1'b1) : in_bt;
        au_q   <= in_au;
        bu_q   <= in_bu;
        gx_q   <= in_au;
        gy_q   <= in_bu;
        sc_q   <= in_sc;
        rt_q   <= '0;
        q_q    <= '0;
        ru_q   <= '0;
        err_q  <= ERR_NONE;
        if (in_func == FUNC_ADD || in_func == FUNC_SUB) begin
          if (in_au == '0 && in_bu == '0) err_q <= ERR_DIV0;
        end else if (in_func == FUNC_MUL || in_func == FUNC_DIV) begin
          ru_q <= in_au;
          if (in_func == FUNC_DIV && in_sc == '0) err_q <= ERR_DIV0;
        end
      end
      ST_GCD: if (div_done) begin
        gx_q <= gy_q;
        gy_q <= div_rem[U-1:0];
      end
      ST_SCL: if (div_done) begin
        // replace units by their quotient over the gcd
        if (scl_q == 2'd0) au_q <= div_quo[U-1:0];
        else bu_q <= div_quo[U-1:0];
      end
      ST_MULA: if (mul_done) pa_q <= mul_p[PW-1:0];
      ST_MULB: if (mul_done) pb_q <= mul_p[PW-1:0];
      ST_QDIV: if (pb_q == '0) err_q <= ERR_DIV0;
      ST_FIN: begin
        unique case (func_q)
          FUNC_ADD, FUNC_SUB: begin
            rt_q <= pk_add[T-1:0];
            ru_q <= gx_q;
            if (pk_add[T]) err_q <= ERR_OVF;
          end
          FUNC_MUL: begin
            rt_q <= pk_mul[T-1:0];
            if (pk_mul[T]) err_q <= ERR_OVF;
          end
          FUNC_DIV: begin
            rt_q <= pk_div[T-1:0];
            if (pk_div[T]) err_q <= ERR_OVF;
          end
          default: begin
            q_q <= pk_q[T-1:0];
            if (pk_q[T]) err_q <= ERR_OVF;
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/dau_serdiv.sv =====
// bit-serial restoring divider: one quotient bit per cycle
`default_nettype none
module dau_serdiv
  import dau_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CntBits = $clog2(W + 1);

  logic [W-1:0]       n_q, d_q, r_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [W:0]         trial;
  logic [W:0]         shifted;

  assign shifted = {r_q, n_q[W-1]};
  assign trial   = shifted - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (!trial[W]) begin
        r_q <= trial[W-1:0];
        n_q <= {n_q[W-2:0], 1'b1};
      end else begin
        r_q <= shifted[W-1:0];
        n_q <= {n_q[W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = n_q;
  assign rem_o  = r_q;

endmodule
`default_nettype wire

// ===== sv/dau_sermul.sv =====
// shift-and-add multiplier: one multiplier bit per cycle
`default_nettype none
module dau_sermul
  import dau_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [2*W-1:0]      prod_o
);

  localparam int unsigned CntBits = $clog2(W + 1);

  logic [2*W-1:0]     acc_q;
  logic [W-1:0]       b_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [W:0]         upper;

  // add into the upper half, then shift right with the carry
  assign upper = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, b_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{W{1'b0}}, a_i};
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= {upper, acc_q[W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire
